### rtl/mesf_pkg.sv
package mesf_pkg;

  localparam int MAX_EDGES_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] CFG_RESET_VAL = 32'h0001_0000;

  localparam logic REG_SPRING = 1'b0;
  localparam logic REG_MEAN   = 1'b1;

  localparam logic [45:0] LIM46    = 46'h3FFF_FFFF_FFFF;
  localparam logic [47:0] ACC_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] ACC_MIN  = 48'h8000_0000_0000;
  localparam logic [31:0] OUT_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] OUT_MIN  = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic signed [31:0] own_z;
    logic signed [31:0] peer_x;
    logic signed [31:0] peer_y;
    logic signed [31:0] peer_z;
    logic [31:0]        rest_length;
    logic               final_edge;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [1:0]         status;
  } out_item_t;

  // one classified edge handed from front to back
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [31:0]        l0;
    logic               skip;
    logic               fin;
  } edge_t;

endpackage

### rtl/mesf_fifo.sv
module mesf_fifo import mesf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  edge_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output edge_t rd_data,
  output logic  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  edge_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wp_r;
  logic [PTR_W-1:0]  rp_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_wr;
  logic              do_rd;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/mesf_front.sv
module mesf_front import mesf_pkg::*; #(
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_wr,
  output edge_t    q_edge
);

  localparam int CNT_W = $clog2(MAX_EDGES + 1);

  logic [CNT_W-1:0] edges_r;
  logic             take;
  logic             skip;

  assign take = push && !q_full;
  assign skip = (edges_r >= CNT_W'(MAX_EDGES));
  assign q_wr = take;

  always_comb begin
    q_edge.dx   = 33'(in_item.own_x) - 33'(in_item.peer_x);
    q_edge.dy   = 33'(in_item.own_y) - 33'(in_item.peer_y);
    q_edge.dz   = 33'(in_item.own_z) - 33'(in_item.peer_z);
    q_edge.l0   = in_item.rest_length;
    q_edge.skip = skip;
    q_edge.fin  = in_item.final_edge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edges_r <= '0;
    end else if (take) begin
      if (in_item.final_edge) begin
        edges_r <= '0;
      end else if (!skip) begin
        edges_r <= edges_r + 1'b1;
      end
    end
  end

endmodule

### rtl/mesf_back.sv
module mesf_back import mesf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_vld,
  input  edge_t       q_edge,
  output logic        q_pop,
  input  logic [31:0] spring_k,
  input  logic [31:0] mean_a,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_MUL, ST_DIV, ST_SQRT, ST_NEXT, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    PH_SQ, PH_LEN, PH_T, PH_R, PH_Q, PH_C, PH_K, PH_A1, PH_A2
  } phase_t;

  state_t             state_r;
  phase_t             ph_r;
  logic [1:0]         comp_r;
  logic [6:0]         cnt_r;
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic [31:0]        l0_r;
  logic               fin_r;
  logic [67:0]        rad_r;
  logic [63:0]        mc_r;
  logic [97:0]        prod_r;
  logic [63:0]        quo_r;
  logic [33:0]        rem_r;
  logic [33:0]        den_r;
  logic [36:0]        sr_rem_r;
  logic [33:0]        root_r;
  logic [45:0]        mag_r;
  logic               neg_r;
  logic [16:0]        q_mag_r;
  logic               q_neg_r;
  logic [62:0]        m_r;
  logic signed [47:0] sum_r [3];
  logic [31:0]        force_r [3];
  logic               sat_r;
  logic               deg_r;
  logic               out_vld_r;
  out_item_t          out_item_r;

  logic signed [32:0] d_sel;
  logic [32:0]        d_abs;
  logic signed [47:0] s_sel;
  logic [47:0]        s_abs;
  logic [64:0]        mul_add;
  logic [34:0]        div_sh;
  logic               div_ge;
  logic [34:0]        div_diff;
  logic [36:0]        sr_sh;
  logic [36:0]        sr_trial;
  logic               sr_ge;
  logic [34:0]        dlen;
  logic [34:0]        dlen_abs;
  logic               quo_ov;
  logic [45:0]        quo_mag;
  logic [46:0]        c_mag;
  logic [48:0]        c_term;
  logic [48:0]        sum49;
  logic               sum_ov;
  logic [47:0]        sum_clamp;
  logic               m_ov;
  logic [62:0]        m_val;
  logic               s_pos;
  logic               f_sat;
  logic [31:0]        f_val;

  assign q_pop    = (state_r == ST_IDLE) && q_vld;
  assign empty    = !out_vld_r;
  assign out_item = out_item_r;

  always_comb begin
    case (comp_r)
      2'd0:    d_sel = dx_r;
      2'd1:    d_sel = dy_r;
      default: d_sel = dz_r;
    endcase
    d_abs = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
    s_sel = sum_r[comp_r];
    s_abs = s_sel[47] ? 48'(-s_sel) : 48'(s_sel);

    mul_add = {1'b0, prod_r[97:34]} + (prod_r[0] ? {1'b0, mc_r} : 65'd0);

    div_sh   = {rem_r, quo_r[63]};
    div_ge   = (div_sh >= {1'b0, den_r});
    div_diff = div_sh - {1'b0, den_r};

    sr_sh    = {sr_rem_r[34:0], rad_r[67:66]};
    sr_trial = {1'b0, root_r, 2'b01};
    sr_ge    = (sr_sh >= sr_trial);

    dlen     = {1'b0, root_r} - {3'b000, l0_r};
    dlen_abs = dlen[34] ? 35'(-dlen) : dlen;

    quo_ov  = |quo_r[63:46];
    quo_mag = quo_ov ? LIM46 : quo_r[45:0];

    c_mag     = prod_r[62:16];
    c_term    = (neg_r ^ q_neg_r) ? 49'(-{2'b00, c_mag}) : {2'b00, c_mag};
    sum49     = {s_sel[47], s_sel} + c_term;
    sum_ov    = (sum49[48] != sum49[47]);
    sum_clamp = sum_ov ? (sum49[48] ? ACC_MIN : ACC_MAX) : sum49[47:0];

    m_ov  = |prod_r[97:79];
    m_val = prod_r[78:16];
    s_pos = !s_sel[47] && (s_sel != 48'sd0);
    if (s_pos) begin
      f_sat = m_ov || (m_val > 63'h8000_0000);
      f_val = f_sat ? OUT_MIN : 32'(63'd0 - m_val);
    end else begin
      f_sat = m_ov || (m_val > 63'h7FFF_FFFF);
      f_val = f_sat ? OUT_MAX : m_val[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ph_r      <= PH_SQ;
      comp_r    <= 2'd0;
      cnt_r     <= '0;
      sat_r     <= 1'b0;
      deg_r     <= 1'b0;
      out_vld_r <= 1'b0;
      sum_r[0]  <= '0;
      sum_r[1]  <= '0;
      sum_r[2]  <= '0;
    end else begin
      if (pop && out_vld_r && (state_r != ST_EMIT)) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_vld) begin
            dx_r   <= q_edge.dx;
            dy_r   <= q_edge.dy;
            dz_r   <= q_edge.dz;
            l0_r   <= q_edge.l0;
            fin_r  <= q_edge.fin;
            rad_r  <= '0;
            comp_r <= 2'd0;
            if (q_edge.skip) begin
              sat_r <= 1'b1;
              if (q_edge.fin) begin
                ph_r    <= PH_K;
                state_r <= ST_START;
              end
            end else begin
              ph_r    <= PH_SQ;
              state_r <= ST_START;
            end
          end
        end
        ST_START: begin
          case (ph_r)
            PH_SQ: begin
              mc_r    <= 64'(d_abs);
              prod_r  <= {64'd0, 1'b0, d_abs};
              cnt_r   <= 7'd34;
              state_r <= ST_MUL;
            end
            PH_LEN: begin
              sr_rem_r <= '0;
              root_r   <= '0;
              cnt_r    <= 7'd34;
              state_r  <= ST_SQRT;
            end
            PH_T: begin
              quo_r   <= 64'({dlen_abs, 16'h0000});
              rem_r   <= '0;
              den_r   <= {2'b00, l0_r};
              neg_r   <= dlen[34];
              cnt_r   <= 7'd64;
              state_r <= ST_DIV;
            end
            PH_R: begin
              quo_r   <= 64'({mag_r, 16'h0000});
              rem_r   <= '0;
              den_r   <= {2'b00, l0_r};
              cnt_r   <= 7'd64;
              state_r <= ST_DIV;
            end
            PH_Q: begin
              quo_r   <= 64'({d_abs, 16'h0000});
              rem_r   <= '0;
              den_r   <= root_r;
              q_neg_r <= d_sel[32];
              cnt_r   <= 7'd64;
              state_r <= ST_DIV;
            end
            PH_C: begin
              mc_r    <= 64'(mag_r);
              prod_r  <= {64'd0, 17'd0, q_mag_r};
              cnt_r   <= 7'd34;
              state_r <= ST_MUL;
            end
            PH_K: begin
              mc_r    <= 64'(s_abs);
              prod_r  <= {64'd0, 2'b00, spring_k};
              cnt_r   <= 7'd34;
              state_r <= ST_MUL;
            end
            PH_A1, PH_A2: begin
              mc_r    <= 64'(m_r);
              prod_r  <= {64'd0, 2'b00, mean_a};
              cnt_r   <= 7'd34;
              state_r <= ST_MUL;
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_MUL: begin
          prod_r <= {mul_add, prod_r[33:1]};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == 7'd1) begin
            state_r <= ST_NEXT;
          end
        end
        ST_DIV: begin
          rem_r <= div_ge ? div_diff[33:0] : div_sh[33:0];
          quo_r <= {quo_r[62:0], div_ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 7'd1) begin
            state_r <= ST_NEXT;
          end
        end
        ST_SQRT: begin
          sr_rem_r <= sr_ge ? (sr_sh - sr_trial) : sr_sh;
          root_r   <= {root_r[32:0], sr_ge};
          rad_r    <= {rad_r[65:0], 2'b00};
          cnt_r    <= cnt_r - 1'b1;
          if (cnt_r == 7'd1) begin
            state_r <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          case (ph_r)
            PH_SQ: begin
              rad_r   <= rad_r + 68'(prod_r[65:0]);
              state_r <= ST_START;
              if (comp_r == 2'd2) begin
                comp_r <= 2'd0;
                ph_r   <= PH_LEN;
              end else begin
                comp_r <= comp_r + 1'b1;
              end
            end
            PH_LEN: begin
              if ((root_r == '0) || (l0_r == '0)) begin
                deg_r  <= 1'b1;
                comp_r <= 2'd0;
                if (fin_r) begin
                  ph_r    <= PH_K;
                  state_r <= ST_START;
                end else begin
                  state_r <= ST_IDLE;
                end
              end else begin
                ph_r    <= PH_T;
                state_r <= ST_START;
              end
            end
            PH_T: begin
              mag_r   <= quo_mag;
              sat_r   <= sat_r | quo_ov;
              ph_r    <= PH_R;
              state_r <= ST_START;
            end
            PH_R: begin
              mag_r   <= quo_mag;
              sat_r   <= sat_r | quo_ov;
              comp_r  <= 2'd0;
              ph_r    <= PH_Q;
              state_r <= ST_START;
            end
            PH_Q: begin
              q_mag_r <= quo_r[16:0];
              ph_r    <= PH_C;
              state_r <= ST_START;
            end
            PH_C: begin
              sum_r[comp_r] <= sum_clamp;
              sat_r         <= sat_r | sum_ov;
              if (comp_r == 2'd2) begin
                comp_r <= 2'd0;
                if (fin_r) begin
                  ph_r    <= PH_K;
                  state_r <= ST_START;
                end else begin
                  state_r <= ST_IDLE;
                end
              end else begin
                comp_r  <= comp_r + 1'b1;
                ph_r    <= PH_Q;
                state_r <= ST_START;
              end
            end
            PH_K, PH_A1, PH_A2: begin
              if (m_ov || (ph_r == PH_A2)) begin
                force_r[comp_r] <= f_val;
                sat_r           <= sat_r | f_sat;
                ph_r            <= PH_K;
                if (comp_r == 2'd2) begin
                  state_r <= ST_EMIT;
                end else begin
                  comp_r  <= comp_r + 1'b1;
                  state_r <= ST_START;
                end
              end else begin
                m_r     <= m_val;
                ph_r    <= (ph_r == PH_K) ? PH_A1 : PH_A2;
                state_r <= ST_START;
              end
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_EMIT: begin
          if (!out_vld_r || pop) begin
            out_item_r.force_x <= force_r[0];
            out_item_r.force_y <= force_r[1];
            out_item_r.force_z <= force_r[2];
            out_item_r.status  <= {deg_r, sat_r};
            out_vld_r          <= 1'b1;
            sum_r[0]           <= '0;
            sum_r[1]           <= '0;
            sum_r[2]           <= '0;
            sat_r              <= 1'b0;
            deg_r              <= 1'b0;
            comp_r             <= 2'd0;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/mesh_edge_stretching_force.sv
// channel   ports                              item
// input     push, full, in_item                one incident edge (in_item_t)
// result    empty, pop, out_item               net force and status (out_item_t)
// config    valid, ready, cfg_index, cfg_data  k or mean edge length, ready always high
//
// an edge in range and not degenerate runs in the back end as three 34-step squarings,
// a 34-step square root, five 64-step divisions and three 34-step products on one
// shared shift-add multiplier and one restoring divider; a final edge adds up to
// nine output-scaling products. reset is synchronous and clears the edge count,
// accumulators, flags and queues. the input queue keeps taking edges while the
// back end works, until it is full, and a finished result waits in its own register
module mesh_edge_stretching_force import mesf_pkg::*; #(
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        valid,
  output logic        ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] spring_k_r;
  logic [31:0] mean_a_r;
  logic        q_wr;
  edge_t       q_wdata;
  logic        q_full;
  logic        q_rd;
  edge_t       q_rdata;
  logic        q_vld;

  assign ready = 1'b1;
  assign full  = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_k_r <= CFG_RESET_VAL;
      mean_a_r   <= CFG_RESET_VAL;
    end else if (valid) begin
      case (cfg_index)
        REG_SPRING: spring_k_r <= cfg_data;
        REG_MEAN:   mean_a_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  mesf_front #(.MAX_EDGES(MAX_EDGES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_edge  (q_wdata)
  );

  mesf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_wr),
    .wr_data   (q_wdata),
    .full      (q_full),
    .rd_en     (q_rd),
    .rd_data   (q_rdata),
    .not_empty (q_vld)
  );

  mesf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_vld    (q_vld),
    .q_edge   (q_rdata),
    .q_pop    (q_rd),
    .spring_k (spring_k_r),
    .mean_a   (mean_a_r),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

### tb/mesh_edge_stretching_force_tb.sv
module mesh_edge_stretching_force_tb;
  import mesf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  localparam int      EDGE_LIMIT  = MAX_EDGES_DEF;
  localparam longint  CYCLE_LIMIT = 64'd4_000_000;
  localparam int      DRAIN_WAIT  = 4000;
  localparam wide_t   LIM_T       = (wide_t'(1) <<< 46) - 1;
  localparam wide_t   SUM_HI      = (wide_t'(1) <<< 47) - 1;
  localparam wide_t   SUM_LO      = -(wide_t'(1) <<< 47);

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        valid = 1'b0;
  logic        ready;
  logic        cfg_index = REG_SPRING;
  logic [31:0] cfg_data = '0;

  // model of the block
  wide_t     k_val, a_val;
  wide_t     acc_x, acc_y, acc_z;
  bit        degen_flag, sat_flag;
  int        edge_cnt;
  out_item_t force_q[$];

  int        mismatch_cnt = 0;
  longint    cycle_cnt = 0;
  int        stall_left = 0;
  row_t      rows[$];

  mesh_edge_stretching_force u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .valid     (valid),
    .ready     (ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("mesh_edge_stretching_force verification failed");
      $finish;
    end
  end

  function automatic wide_t clamp_sat(wide_t v, wide_t lo, wide_t hi);
    if (v > hi) begin
      sat_flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat_flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic wide_t sqrt_floor(wide_t s);
    wide_t r, c;
    r = 0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (wide_t'(1) <<< b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic void add_edge(in_item_t it);
    wide_t ox, oy, oz, px, py, pz, dx, dy, dz, len, l0, t, r;
    ox = it.own_x;  oy = it.own_y;  oz = it.own_z;
    px = it.peer_x; py = it.peer_y; pz = it.peer_z;
    l0 = 0;
    l0[31:0] = it.rest_length;
    dx = ox - px;
    dy = oy - py;
    dz = oz - pz;
    len = sqrt_floor(dx * dx + dy * dy + dz * dz);
    if (len == 0 || l0 == 0) begin
      degen_flag = 1'b1;
      return;
    end
    t = clamp_sat((len - l0) * 65536 / l0, -LIM_T, LIM_T);
    r = clamp_sat(t * 65536 / l0, -LIM_T, LIM_T);
    acc_x = clamp_sat(acc_x + r * (dx * 65536 / len) / 65536, SUM_LO, SUM_HI);
    acc_y = clamp_sat(acc_y + r * (dy * 65536 / len) / 65536, SUM_LO, SUM_HI);
    acc_z = clamp_sat(acc_z + r * (dz * 65536 / len) / 65536, SUM_LO, SUM_HI);
  endfunction

  function automatic logic [31:0] scale_axis(wide_t s);
    wide_t m;
    bit    ov;
    wide_t top;
    top = wide_t'(1) <<< 63;
    m = (s < 0) ? -s : s;
    m = m * k_val / 65536;
    ov = (m >= top);
    if (!ov) begin
      m = m * a_val / 65536;
      ov = (m >= top);
    end
    if (!ov) begin
      m = m * a_val / 65536;
      ov = (m >= top);
    end
    if (s > 0) begin
      if (ov || m > 64'h8000_0000) begin
        sat_flag = 1'b1;
        return OUT_MIN;
      end
      m = -m;
      return m[31:0];
    end
    if (ov || m > 64'h7FFF_FFFF) begin
      sat_flag = 1'b1;
      return OUT_MAX;
    end
    return m[31:0];
  endfunction

  function automatic void clear_vertex();
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    degen_flag = 1'b0;
    sat_flag = 1'b0;
    edge_cnt = 0;
  endfunction

  function automatic bit predict_force(in_item_t it, output out_item_t res);
    res = '0;
    if (edge_cnt >= EDGE_LIMIT) sat_flag = 1'b1;
    else begin
      edge_cnt++;
      add_edge(it);
    end
    if (!it.final_edge) return 1'b0;
    res.force_x = scale_axis(acc_x);
    res.force_y = scale_axis(acc_y);
    res.force_z = scale_axis(acc_z);
    res.status  = {degen_flag, sat_flag};
    clear_vertex();
    return 1'b1;
  endfunction

  function automatic in_item_t mk(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                  logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                  logic [31:0] l0, logic fin);
    in_item_t it;
    it.own_x = ox;  it.own_y = oy;  it.own_z = oz;
    it.peer_x = px; it.peer_y = py; it.peer_z = pz;
    it.rest_length = l0;
    it.final_edge = fin;
    return it;
  endfunction

  task automatic send_edge(in_item_t it, bit typed, out_item_t want);
    int        gap;
    out_item_t res;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full !== 1'b0);
    if (predict_force(it, res)) force_q.push_back(typed ? want : res);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (ready !== 1'b1);
    valid <= 1'b0;
    if (idx == REG_SPRING) k_val = data;
    else a_val = data;
    @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [31:0] near(logic [31:0] base, int span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic run_vertices(int n_items);
    int        sent, n_edges, kind;
    logic [31:0] cx, cy, cz, l0;
    in_item_t  it;
    out_item_t none;
    none = '0;
    sent = 0;
    while (sent < n_items) begin
      n_edges = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
      cx = $urandom_range(0, 1) ? $urandom() : near(0, 1 << 22);
      cy = near(0, 1 << 22);
      cz = near(0, 1 << 22);
      for (int e = 0; e < n_edges; e++) begin
        kind = $urandom_range(0, 19);
        l0 = $urandom_range(1, 1 << 19);
        it = mk(cx, cy, cz, near(cx, 1 << 18), near(cy, 1 << 18), near(cz, 1 << 18),
                l0, e == n_edges - 1);
        if (kind == 0) begin
          it = mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom_range(0, 1));
          if (e == n_edges - 1) it.final_edge = 1'b1;
        end else if (kind == 1) begin
          it.peer_x = cx;
          it.peer_y = cy;
          it.peer_z = cz;
        end else if (kind == 2) begin
          it.rest_length = '0;
        end
        send_edge(it, 1'b0, none);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (force_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected item: %p", out_item);
        end else if (out_item !== force_q[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("force mismatch: expected %p actual %p", force_q[0], out_item);
          void'(force_q.pop_front());
        end else begin
          void'(force_q.pop_front());
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    row_t r;
    k_val = CFG_RESET_VAL;
    a_val = CFG_RESET_VAL;
    clear_vertex();

    // zero length, zero rest length, unit stretch, tiny edge
    r.typed = 1'b1;
    r.item = mk(0, 0, 0, 0, 0, 0, 32'h0001_0000, 1'b1);
    r.want = '{force_x: 0, force_y: 0, force_z: 0, status: 2'd2};
    rows.push_back(r);
    r.item = mk(32'h0001_0000, 0, 0, 0, 0, 0, 0, 1'b1);
    rows.push_back(r);
    r.item = mk(32'h0002_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 1'b1);
    r.want = '{force_x: -32'sd65536, force_y: 0, force_z: 0, status: 2'd0};
    rows.push_back(r);
    r.item = mk(1, 0, 0, 0, 0, 0, 1, 1'b1);
    r.want = '{force_x: 0, force_y: 0, force_z: 0, status: 2'd0};
    rows.push_back(r);

    r.typed = 1'b0;
    r.want = '0;
    // one vertex, several edges
    r.item = mk(0, 32'h0003_0000, 0, 0, 0, 0, 32'h0001_8000, 1'b0);
    rows.push_back(r);
    r.item = mk(0, 0, 32'hFFFE_0000, 0, 0, 0, 32'h0004_0000, 1'b0);
    rows.push_back(r);
    r.item = mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 1'b0);
    rows.push_back(r);
    r.item = mk(32'hFFFF_8000, 32'h0000_4000, 32'h0002_0000, 32'h0001_0000, 0, 0,
                32'h0000_C000, 1'b1);
    rows.push_back(r);
    // extremes
    r.item = mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1'b1);
    rows.push_back(r);
    r.item = mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    rows.push_back(r);
    r.item = mk(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1'b0);
    rows.push_back(r);
    r.item = mk(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 1, 1'b0);
    rows.push_back(r);
    r.item = mk(32'h0000_0100, 0, 0, 0, 0, 0, 32'h0000_0001, 1'b1);
    rows.push_back(r);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_edge(rows[i].item, rows[i].typed, rows[i].want);
    run_vertices(150);
    drain();

    write_reg(REG_SPRING, 32'h0000_0000);
    write_reg(REG_MEAN, 32'hFFFF_FFFF);
    run_vertices(100);
    drain();

    write_reg(REG_SPRING, 32'hFFFF_FFFF);
    write_reg(REG_MEAN, 32'h0000_0000);
    run_vertices(100);
    drain();

    write_reg(REG_SPRING, 32'hFFFF_FFFF);
    write_reg(REG_MEAN, 32'hFFFF_FFFF);
    run_vertices(100);
    drain();

    write_reg(REG_SPRING, $urandom());
    write_reg(REG_MEAN, $urandom());
    run_vertices(100);
    drain();

    write_reg(REG_SPRING, 32'h0002_0000 + $urandom_range(0, 32'hFFFF));
    write_reg(REG_MEAN, 32'h0000_8000 + $urandom_range(0, 32'hFFFF));
    run_vertices(190);
    drain();

    if (mismatch_cnt == 0 && force_q.size() == 0) begin
      $display("mesh_edge_stretching_force verification clean");
    end else begin
      $display("mesh_edge_stretching_force verification failed");
    end
    $finish;
  end

endmodule
